>>> design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked only out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/afrp_pkg.sv
`default_nettype none

package afrp_pkg;

    // Frame constants
    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [15:0] HEADER_LEN = 16'd12;
    localparam logic [7:0]  CSUM_BASE  = 8'hFF;
    localparam logic [15:0] SRC_BYTES  = 16'd8;
    localparam logic [15:0] SHORT_BYTES = 16'd2;

    // Register reset values
    localparam logic [7:0]  TYPE_RESET    = 8'h90;
    localparam logic [15:0] MIN_LEN_RESET = 16'd12;

    // Configuration register indexes
    localparam logic CFG_EXP_TYPE = 1'b0;
    localparam logic CFG_MIN_LEN  = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CSUM  = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } status_t;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_TYPE    = 4'd3,
        PH_SRC     = 4'd4,
        PH_SHORT   = 4'd5,
        PH_OPT     = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CSUM    = 4'd8,
        PH_SKIP    = 4'd9
    } phase_t;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        status_t     frame_status;
        logic [63:0] source_address;
        logic [15:0] short_address;
        logic [7:0]  receive_options;
        logic [15:0] payload_length;
    } result_t;

    localparam int DATA_BITS  = 130;
    localparam int TDATA_BITS = 136;

endpackage

`default_nettype wire

>>> design/afrp_core.sv
`default_nettype none

`include "assert_macros.svh"

module afrp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    output logic                   res_valid,
    output afrp_pkg::result_t      res
);
    import afrp_pkg::*;

    logic [7:0]  exp_type_reg;
    logic [15:0] min_len_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [63:0] src_addr_reg, src_addr_next;
    logic [15:0] short_addr_reg, short_addr_next;
    logic [7:0]  opts_reg, opts_next;

    logic [15:0] full_len;
    logic [15:0] payload_len;
    logic [15:0] count_inc;
    logic        len_short;

    assign full_len    = {frame_len_reg[15:8], in_byte};
    assign payload_len = frame_len_reg - HEADER_LEN;
    assign count_inc   = byte_count_reg + 16'd1;
    assign len_short   = (full_len < min_len_reg) || (full_len < HEADER_LEN);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_type_reg <= TYPE_RESET;
            min_len_reg  <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXP_TYPE: exp_type_reg <= cfg_data[7:0];
                CFG_MIN_LEN:  min_len_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Next state and header accumulation
    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        src_addr_next   = src_addr_reg;
        short_addr_next = short_addr_reg;
        opts_next       = opts_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte == START_BYTE)
                    phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_len_next = {in_byte, 8'h00};
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_len_next  = full_len;
                sum_next        = '0;
                src_addr_next   = '0;
                short_addr_next = '0;
                opts_next       = '0;
                byte_count_next = '0;
                phase_next      = len_short ? PH_HUNT : PH_TYPE;
            end
            PH_TYPE:
            begin
                sum_next = sum_reg + in_byte;
                if (in_byte != exp_type_reg)
                begin
                    // skip the remaining data bytes and the checksum
                    byte_count_next = frame_len_reg;
                    phase_next      = PH_SKIP;
                end
                else
                begin
                    byte_count_next = '0;
                    phase_next      = PH_SRC;
                end
            end
            PH_SRC:
            begin
                sum_next      = sum_reg + in_byte;
                src_addr_next = {src_addr_reg[55:0], in_byte};
                if (count_inc >= SRC_BYTES)
                begin
                    byte_count_next = '0;
                    phase_next      = PH_SHORT;
                end
                else
                    byte_count_next = count_inc;
            end
            PH_SHORT:
            begin
                sum_next        = sum_reg + in_byte;
                short_addr_next = {short_addr_reg[7:0], in_byte};
                if (count_inc >= SHORT_BYTES)
                begin
                    byte_count_next = '0;
                    phase_next      = PH_OPT;
                end
                else
                    byte_count_next = count_inc;
            end
            PH_OPT:
            begin
                sum_next        = sum_reg + in_byte;
                opts_next       = in_byte;
                byte_count_next = '0;
                phase_next      = (frame_len_reg > HEADER_LEN) ? PH_PAYLOAD : PH_CSUM;
            end
            PH_PAYLOAD:
            begin
                sum_next        = sum_reg + in_byte;
                byte_count_next = count_inc;
                if (count_inc >= payload_len)
                    phase_next = PH_CSUM;
            end
            PH_CSUM:
            begin
                phase_next = PH_HUNT;
            end
            PH_SKIP:
            begin
                if (byte_count_reg != '0)
                    byte_count_next = byte_count_reg - 16'd1;
                if (byte_count_reg <= 16'd1)
                    phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Result for the byte at the input
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        case (phase_reg)
            PH_LEN_LO:
            begin
                if (len_short)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_STATUS;
                    res.frame_status = ST_TOO_SHORT;
                end
            end
            PH_TYPE:
            begin
                if (in_byte != exp_type_reg)
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_STATUS;
                    res.frame_status   = ST_BAD_TYPE;
                    res.payload_length = payload_len;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = in_byte;
                res.payload_index = byte_count_reg;
            end
            PH_CSUM:
            begin
                res_valid           = 1'b1;
                res.kind            = KIND_STATUS;
                res.frame_status    = (in_byte == (CSUM_BASE - sum_reg)) ? ST_OK : ST_BAD_CSUM;
                res.source_address  = src_addr_reg;
                res.short_address   = short_addr_reg;
                res.receive_options = opts_reg;
                res.payload_length  = payload_len;
            end
            default: ;
        endcase
    end

    // Parser state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            frame_len_reg  <= '0;
            byte_count_reg <= '0;
            sum_reg        <= '0;
            src_addr_reg   <= '0;
            short_addr_reg <= '0;
            opts_reg       <= '0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            src_addr_reg   <= src_addr_next;
            short_addr_reg <= short_addr_next;
            opts_reg       <= opts_next;
        end
    end

    // Payload index always stays inside the announced payload
    `ASSERT_IMPL(a_payload_idx, clk, rst_n, phase_reg == PH_PAYLOAD, byte_count_reg < payload_len)
    // A skip run never sits at a zero count
    `ASSERT_IMPL(a_skip_count, clk, rst_n, phase_reg == PH_SKIP, byte_count_reg != '0)
    // Payload phase only ever holds a frame longer than the header
    `ASSERT_IMPL(a_payload_len, clk, rst_n, phase_reg == PH_PAYLOAD, frame_len_reg > HEADER_LEN)

endmodule

`default_nettype wire

>>> design/api_frame_receive_parser_top.sv
// Channel   | Dir | Signals                               | Content
// s_axis    | in  | tvalid, tready, tdata[7:0]            | received serial byte
// m_axis    | out | tvalid, tready, tdata[135:0], tuser   | payload byte or frame status
// cfg       | in  | cfg_we, cfg_index, cfg_data[15:0]     | register writes, no read-back
//
// One byte per clock while s_axis_tready is high: each accepted byte is parsed
// in the cycle it arrives and its result, if any, is registered on the same edge
// (output register, or the skid register when the output is held) for m_axis.
// A two-entry output stage (output register plus skid register) keeps s_axis_tready
// a register; it drops only while both entries hold results.
// Reset (rst_n low, asynchronous) returns the parser to hunting for the start byte.

`default_nettype none

`include "assert_macros.svh"

module api_frame_receive_parser_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // rx_byte[7:0]
    input  wire logic [7:0]                    s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // payload_byte[7:0], payload_index[23:8], frame_status[25:24],
    // source_address[89:26], short_address[105:90], receive_options[113:106],
    // payload_length[129:114], zero fill[135:130]
    output logic [afrp_pkg::TDATA_BITS-1:0]    m_axis_tdata,
    // result_kind
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import afrp_pkg::*;

    logic    s_accept;
    logic    res_valid;
    result_t res;
    logic    out_take;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;

    afrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (s_accept),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s_accept && res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of both entries
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (s_accept && res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {{(TDATA_BITS - DATA_BITS){1'b0}},
                            out_reg.payload_length,
                            out_reg.receive_options,
                            out_reg.short_address,
                            out_reg.source_address,
                            out_reg.frame_status,
                            out_reg.payload_index,
                            out_reg.payload_byte};

    // The skid entry is only ever filled behind a held output entry
    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A result arriving against a stalled full output goes to the skid entry
    `ASSERT_NEXT(a_skid_fill, clk, rst_n,
        s_accept && res_valid && out_valid_reg && !m_axis_tready, skid_valid_reg)
    // A stalled output with an empty skid keeps the output entry
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !m_axis_tready, out_valid_reg)

endmodule

`default_nettype wire
